FILE: rtl/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern scanner.
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int MAX_PATTERN_BYTES = 32;
    localparam int OFFSET_BITS       = 32;
    localparam int PAT_IDX_W         = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam int LEN_W             = 6;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 64;
    localparam int PAT_WORDS         = 4;
    localparam int ADDR_W            = 64;
    localparam int OFF_OUT_W         = 32;
    localparam int MASK_W            = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_W0 = 3'd0,
        CFG_PAT_W1 = 3'd1,
        CFG_PAT_W2 = 3'd2,
        CFG_PAT_W3 = 3'd3,
        CFG_WILD   = 3'd4,
        CFG_LEN    = 3'd5,
        CFG_BASE   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
        logic [OFF_OUT_W-1:0] match_offset;
    } t_out_item;

    // Live configuration as seen by the scan logic; pattern bytes, wildcards and the
    // in-use mask are lined up with the window cells, cell 0 holding the newest byte
    typedef struct packed {
        logic [MAX_PATTERN_BYTES-1:0][7:0] pat_bytes;
        logic [MAX_PATTERN_BYTES-1:0]      wild;
        logic [MAX_PATTERN_BYTES-1:0]      live;
        logic [LEN_W-1:0]                  len;
        logic [ADDR_W-1:0]                 base;
    } t_cfg;

    typedef struct packed {
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

FILE: rtl/wbps_cfg.sv
// Configuration register bank with pattern length clamp and pattern alignment to the window.
`timescale 1ns / 1ps

module wbps_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wbps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output wbps_pkg::t_cfg                 o_cfg
);
    import wbps_pkg::*;

    logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] r_pat;
    logic [MASK_W-1:0]                    r_wild;
    logic [LEN_W-1:0]                     r_len;
    logic [ADDR_W-1:0]                    r_base;
    logic [PAT_WORDS*CFG_DATA_W-1:0]      pat_flat;
    logic [LEN_W-1:0]                     len_c;
    logic [LEN_W-1:0]                     pad;
    logic [MAX_PATTERN_BYTES-1:0][7:0]    rev_pat;
    logic [MAX_PATTERN_BYTES-1:0]         rev_wild;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_wild <= '0;
            r_len  <= '0;
            r_base <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                CFG_PAT_W0, CFG_PAT_W1, CFG_PAT_W2, CFG_PAT_W3: begin
                    r_pat[i_cfg_idx[1:0]] <= i_cfg_data;
                end
                CFG_WILD: r_wild <= i_cfg_data[MASK_W-1:0];
                CFG_LEN:  r_len  <= i_cfg_data[LEN_W-1:0];
                CFG_BASE: r_base <= i_cfg_data[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    assign pat_flat = r_pat;

    always_comb begin
        // Clamp an oversized length to the chain size
        if (r_len > LEN_W'(MAX_PATTERN_BYTES)) begin
            len_c = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            len_c = r_len;
        end
        pad = LEN_W'(MAX_PATTERN_BYTES) - len_c;
        for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
            rev_pat[k]  = pat_flat[(MAX_PATTERN_BYTES-1-k)*8 +: 8];
            rev_wild[k] = r_wild[MAX_PATTERN_BYTES-1-k];
        end
        // Cell w faces pattern byte len-1-w; cells past the pattern see zeros
        o_cfg.pat_bytes = rev_pat >> {pad, 3'b000};
        o_cfg.wild      = rev_wild >> pad;
        o_cfg.live      = ~({MAX_PATTERN_BYTES{1'b1}} << len_c);
        o_cfg.len       = len_c;
        o_cfg.base      = r_base;
    end

endmodule

FILE: rtl/wbps_cell.sv
// One window cell: holds a byte of the recent window and checks it against its pattern byte.
`timescale 1ns / 1ps

module wbps_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wbps_pkg::t_cell_ctl  i_ctl,
    input  logic [7:0]           i_prev_byte,
    input  logic                 i_prev_full,
    input  logic [7:0]           i_pat_byte,
    input  logic                 i_wild,
    input  logic                 i_live,
    output logic [7:0]           o_byte,
    output logic                 o_full,
    output logic                 o_fit
);
    import wbps_pkg::*;

    logic [7:0] r_byte;
    logic       r_full;

    // Judge the byte this cell takes on the shift, so the incoming item counts at once
    assign o_fit = !i_live || (i_prev_full && (i_wild || (i_prev_byte == i_pat_byte)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
            r_full <= 1'b0;
        end else if (i_ctl.clear) begin
            r_byte <= '0;
            r_full <= 1'b0;
        end else if (i_ctl.shift) begin
            r_byte <= i_prev_byte;
            r_full <= i_prev_full;
        end
    end

    assign o_byte = r_byte;
    assign o_full = r_full;

endmodule

FILE: rtl/wildcard_byte_pattern_scanner_core.sv
// Top level of the wildcard byte pattern scanner: handshakes, cell chain and result register.
//
// Channel   Direction  Handshake                Payload
// in        input      i_in_valid / o_in_ready  i_in_data  (data_byte, last_byte)
// out       output     o_out_valid / i_out_ready o_out_data (found, match_address, match_offset)
// cfg       input      i_cfg_we                 i_cfg_idx, i_cfg_data
//
// One item per cycle while o_in_ready is high; window cells shift on each accept until a match.
// A result appears in the cycle after the item that causes it, held in the output register.
// The input is taken while the output register is empty or being drained in the same cycle.
// Reset clears the chain, the byte position, the reported flag, the configuration registers
// and the output valid flag; the output data register is left as it is.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  wbps_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output wbps_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wbps_pkg::*;

    t_cfg                              cfg;
    t_cell_ctl                         cell_ctl;
    logic [MAX_PATTERN_BYTES-1:0][7:0] win_byte;
    logic [MAX_PATTERN_BYTES-1:0]      win_full;
    logic [MAX_PATTERN_BYTES-1:0]      fit;

    logic                   r_out_valid;
    t_out_item              r_out;
    logic                   r_reported;
    logic [OFFSET_BITS-1:0] r_pos;

    logic                   accept;
    logic                   active;
    logic                   match;
    logic                   emit;
    logic [OFFSET_BITS-1:0] pos_p1;
    logic [OFFSET_BITS-1:0] off;

    wbps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign active     = accept && !r_reported;

    assign cell_ctl.shift = active;
    assign cell_ctl.clear = accept && i_in_data.last_byte;

    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
        logic [7:0] prev_byte;
        logic       prev_full;
        if (j == 0) begin : g_head
            assign prev_byte = i_in_data.data_byte;
            assign prev_full = 1'b1;
        end else begin : g_body
            assign prev_byte = win_byte[j-1];
            assign prev_full = win_full[j-1];
        end

        wbps_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cell_ctl),
            .i_prev_byte (prev_byte),
            .i_prev_full (prev_full),
            .i_pat_byte  (cfg.pat_bytes[j]),
            .i_wild      (cfg.wild[j]),
            .i_live      (cfg.live[j]),
            .o_byte      (win_byte[j]),
            .o_full      (win_full[j]),
            .o_fit       (fit[j])
        );
    end

    // Cells past the pattern always fit, so an empty pattern matches at once
    assign match = &fit;

    assign emit   = active && (match || i_in_data.last_byte);
    assign pos_p1 = r_pos + OFFSET_BITS'(1);
    assign off    = (cfg.len == '0) ? '0 : (pos_p1 - OFFSET_BITS'(cfg.len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_reported  <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            // Region end clears the scan state, match or not
            if (accept && i_in_data.last_byte) begin
                r_reported <= 1'b0;
                r_pos      <= '0;
            end else if (active) begin
                r_pos <= pos_p1;
                if (match) begin
                    r_reported <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out.found <= match;
            if (match) begin
                r_out.match_address <= cfg.base + ADDR_W'(off);
                r_out.match_offset  <= OFF_OUT_W'(off);
            end else begin
                r_out.match_address <= '0;
                r_out.match_offset  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sim/tb_wildcard_byte_pattern_scanner_core.sv
// Self-checking testbench for the wildcard byte pattern scanner core.
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scanner_core;
    import wbps_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;  // decoded by nothing
    localparam int GAP_MAX       = 12;
    localparam int TARGET_BYTES  = 1000;
    localparam int PHASE_BYTES   = 100;
    localparam int SETTLE_CYCLES = 4;

    // Tracks scan state and configuration, and holds the reports still owed by the block
    class scan_scoreboard;
        logic [255:0] pat_flat;
        logic [31:0]  wild;
        logic [5:0]   pat_len;
        logic [63:0]  base;
        logic [7:0]   recent[32];
        logic [31:0]  pos;
        int           seen;
        bit           reported;
        t_out_item    awaited_reports[$];
        int           mismatches;
        int           hits;
        int           misses;

        function new();
            pat_flat   = '0;
            wild       = '0;
            pat_len    = '0;
            base       = '0;
            mismatches = 0;
            hits       = 0;
            misses     = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            foreach (recent[i]) recent[i] = '0;
            pos      = '0;
            seen     = 0;
            reported = 0;
        endfunction

        function int eff_len();
            return (pat_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pat_len);
        endfunction

        function logic [7:0] pat_byte(int i);
            return pat_flat[i*8 +: 8];
        endfunction

        // Newest byte sits in entry 0, so pattern byte i lines up with entry n-1-i
        function bit window_ok(int n);
            if (seen < n) return 0;
            for (int i = 0; i < n; i++) begin
                if (!wild[i] && recent[n-1-i] != pat_byte(i)) return 0;
            end
            return 1;
        endfunction

        function void take_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
            case (idx)
                CFG_PAT_W0, CFG_PAT_W1, CFG_PAT_W2, CFG_PAT_W3: begin
                    pat_flat[(int'(idx) - int'(CFG_PAT_W0))*64 +: 64] = d;
                end
                CFG_WILD: wild    = d[31:0];
                CFG_LEN:  pat_len = d[5:0];
                CFG_BASE: base    = d;
                default: ;
            endcase
        endfunction

        function void note_byte(t_in_item it);
            t_out_item   rep;
            logic [31:0] off;
            int          n;
            if (!reported) begin
                n = eff_len();
                for (int i = 31; i > 0; i--) recent[i] = recent[i-1];
                recent[0] = it.data_byte;
                if (seen < 32) seen++;
                if (n == 0 || window_ok(n)) begin
                    off                = (n == 0) ? '0 : pos + 32'd1 - 32'(n);
                    rep.found          = 1'b1;
                    rep.match_address  = base + 64'(off);
                    rep.match_offset   = off;
                    reported           = 1;
                    hits++;
                    awaited_reports.push_back(rep);
                end else if (it.last_byte) begin
                    rep = '0;
                    misses++;
                    awaited_reports.push_back(rep);
                end
                pos++;
            end
            if (it.last_byte) clear_scan();
        endfunction

        function void flag(string what, t_out_item want, t_out_item got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%0t: %s: expected found=%0b addr=%h off=%h, got found=%0b addr=%h off=%h",
                         $time, what, want.found, want.match_address, want.match_offset,
                         got.found, got.match_address, got.match_offset);
            end
        endfunction

        function void check_report(t_out_item got);
            t_out_item want;
            if (awaited_reports.size() == 0) begin
                flag("report with none awaited", '0, got);
                return;
            end
            want = awaited_reports.pop_front();
            if (got.found !== want.found || got.match_address !== want.match_address ||
                got.match_offset !== want.match_offset) begin
                flag("report mismatch", want, got);
            end
        endfunction

        function void close();
            if (awaited_reports.size() != 0) begin
                $display("%0d reports never arrived", awaited_reports.size());
                mismatches += awaited_reports.size();
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_ready;
    t_in_item               i_in_data = '0;
    logic                   o_out_valid;
    logic                   i_out_ready = 1'b1;
    t_out_item              o_out_data;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = CFG_PAT_W0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    scan_scoreboard sb;
    logic [7:0]     region_q[$];
    bit             calm;
    int             bytes_sent;
    int             regions;
    int             settings;

    wildcard_byte_pattern_scanner_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) sb.check_report(o_out_data);
            if (i_in_valid && o_in_ready) sb.note_byte(i_in_data);
        end
    end

    // Result side: stall a random number of cycles before each report
    initial begin
        int stall;
        forever begin
            stall = calm ? 0 : $urandom_range(0, GAP_MAX);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Leaves valid high on return; drain() or a gap in the next call takes it down
    task automatic send_item(logic [7:0] b, logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{data_byte: b, last_byte: last};
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic send_region();
        for (int i = 0; i < region_q.size(); i++) send_item(region_q[i], i == region_q.size() - 1);
        regions++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic poke_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] d);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= d;
        @(posedge i_clk);
        sb.take_reg(idx, d);
    endtask

    // Junk in the unused upper bits of the mask and length words must be dropped
    task automatic apply_setting(logic [255:0] pat, logic [31:0] mask, logic [5:0] len,
                                 logic [63:0] b);
        poke_reg(CFG_PAT_W0, pat[63:0]);
        poke_reg(CFG_PAT_W1, pat[127:64]);
        poke_reg(CFG_PAT_W2, pat[191:128]);
        poke_reg(CFG_PAT_W3, pat[255:192]);
        poke_reg(CFG_WILD, {$urandom, mask});
        poke_reg(CFG_LEN, {$urandom, 26'($urandom), len});
        poke_reg(CFG_BASE, b);
        poke_reg(CFG_SPARE, {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic random_setting(int k);
        logic [255:0] pat;
        logic [31:0]  mask;
        logic [5:0]   len;
        logic [63:0]  b;
        for (int i = 0; i < 8; i++) pat[i*32 +: 32] = $urandom;
        case ($urandom_range(0, 7))
            0:       pat = '0;
            1:       pat = '1;
            default: ;
        endcase
        case (k % 6)
            0: begin len = 6'd32; mask = '0; end
            1: begin len = 6'd63; mask = $urandom & $urandom; end
            2: begin len = '0; mask = $urandom; end
            3: begin len = 6'd1; mask = '0; end
            4: begin len = 6'($urandom_range(33, 63)); mask = '1; end
            default: begin
                len  = 6'($urandom_range(1, 12));
                mask = $urandom & $urandom & $urandom;
            end
        endcase
        case ($urandom_range(0, 3))
            0:       b = '0;
            1:       b = '1;
            default: b = {$urandom, $urandom};
        endcase
        calm = ($urandom_range(0, 3) == 0);
        apply_setting(pat, mask, len, b);
    endtask

    // Mostly plant the pattern with random fill; spoil a fixed byte now and then
    task automatic random_region();
        int n;
        int p;
        int k;
        int len;
        bit plant;
        bit spoil;
        len   = sb.eff_len();
        n     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, len + 8);
        plant = ($urandom_range(0, 9) < 7);
        spoil = ($urandom_range(0, 3) == 0);
        region_q.delete();
        repeat (n) region_q.push_back(8'($urandom));
        if (plant && len > 0 && len <= n) begin
            p = $urandom_range(0, n - len);
            for (int i = 0; i < len; i++) begin
                if (!sb.wild[i]) region_q[p+i] = sb.pat_byte(i);
            end
            if (spoil) begin
                k = $urandom_range(0, len - 1);
                if (!sb.wild[k]) region_q[p+k] ^= 8'($urandom_range(1, 255));
            end
        end
        send_region();
    endtask

    initial begin
        int phase;
        int phase_start;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values give an empty pattern: hit at offset 0 on the first byte
        region_q = '{8'hFF, 8'h00};
        send_region();
        region_q = '{8'h00};
        send_region();
        drain();

        // Pattern 00 ?? A5, base at the top of the address space
        apply_setting({{3{64'hFFFF_FFFF_FFFF_FFFF}}, 64'h0000_0000_00A5_FF00},
                      32'h0000_0002, 6'd3, 64'hFFFF_FFFF_FFFF_FFFF);
        region_q = '{8'h12, 8'h00, 8'h77, 8'hA5};        // hit on the final byte, address wraps
        send_region();
        region_q = '{8'h00, 8'h11};                      // region too short for the pattern
        send_region();
        region_q = '{8'h00, 8'h00, 8'hA5, 8'h33, 8'h44}; // trailing bytes after a hit
        send_region();
        region_q = '{8'hFF};
        send_region();
        drain();

        phase = 0;
        while (bytes_sent < TARGET_BYTES) begin
            random_setting(phase);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                random_region();
                if ($urandom_range(0, 19) == 0) drain();
            end
            drain();
            phase++;
        end

        sb.close();
        $display("ran %0d regions of %0d bytes in total over %0d register settings",
                 regions, bytes_sent, settings);
        $display("checked %0d hit reports and %0d miss reports", sb.hits, sb.misses);
        if (sb.mismatches == 0) begin
            $display("tb_wildcard_byte_pattern_scanner_core: done, clean");
        end else begin
            $display("tb_wildcard_byte_pattern_scanner_core: done, errors");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout waiting on the scanner");
        $display("tb_wildcard_byte_pattern_scanner_core: done, errors");
        $finish;
    end

endmodule
